/* sv/bmf_pkg.sv */
`default_nettype none

package bmf_pkg;

  // protocol limits
  localparam int MAX_PACKETS      = 255;
  localparam int BYTES_PER_PACKET = 7;
  localparam int LEN_W            = 11;
  localparam int PKT_W            = 9;

  // frame constants
  localparam logic [15:0] PGN_TP_CM   = 16'd60416;
  localparam logic [15:0] PGN_TP_DT   = 16'd60160;
  localparam logic [7:0]  CTRL_BAM    = 8'd32;
  localparam logic [7:0]  GLOBAL_ADDR = 8'd255;
  localparam logic [7:0]  PAD_BYTE    = 8'hFF;
  localparam logic [LEN_W-1:0] MIN_LENGTH = 11'd8;

  // divide by 7: (x * 2341) >> 14 is exact for x below 2054
  localparam logic [LEN_W:0] RECIP_7     = 12'd2341;
  localparam int             RECIP_SHIFT = 14;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_FRAME     = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_IDLE_DATA = 2'd3
  } status_t;

  typedef enum logic {
    CFG_SOURCE_ADDRESS = 1'b0,
    CFG_OUT_PORT       = 1'b1
  } cfg_index_t;

  typedef struct packed {
    opcode_t          opcode;
    logic [LEN_W-1:0] message_length;
    logic [17:0]      message_pgn;
    logic [7:0]       data_byte;
  } bmf_in_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] frame_pgn;
    logic [7:0]  destination;
    logic [7:0]  frame_source;
    logic [1:0]  frame_port;
    logic [63:0] payload;
    logic        message_done;
  } bmf_out_t;

  // result of one processed item, handed to the output stage
  typedef struct packed {
    logic     valid;
    bmf_out_t data;
  } bmf_res_t;

endpackage

`default_nettype wire

/* sv/bmf_framer.sv */
`default_nettype none

module bmf_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bmf_pkg::bmf_in_t  item,
  input  wire logic              step,
  input  wire logic [7:0]        source_address,
  input  wire logic [1:0]        out_port,
  output bmf_pkg::bmf_res_t      res
);
  import bmf_pkg::*;

  logic             busy, busy_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       seq, seq_next;
  logic [2:0]       fill, fill_next;
  logic [55:0]      pk, pk_next;

  logic [LEN_W:0]     len_bias;
  logic [2*LEN_W+1:0] prod;
  logic [PKT_W-1:0]   packets;
  logic [55:0]        pk_upd;
  logic [2:0]         fill_inc;
  logic [LEN_W-1:0]   left_dec;
  logic [63:0]        dt_payload;

  // packet count, byte insert and data frame assembly
  always_comb begin
    len_bias = {1'b0, item.message_length} + (LEN_W+1)'(BYTES_PER_PACKET - 1);
    prod     = len_bias * RECIP_7;
    packets  = prod[RECIP_SHIFT +: PKT_W];
    fill_inc = fill + 3'd1;
    left_dec = bytes_left - {{(LEN_W-1){1'b0}}, 1'b1};
    for (int i = 0; i < BYTES_PER_PACKET; i++) begin
      pk_upd[8*i +: 8] = (fill == 3'(i)) ? item.data_byte : pk[8*i +: 8];
    end
    dt_payload[7:0] = seq;
    for (int i = 0; i < BYTES_PER_PACKET; i++) begin
      dt_payload[8*(i+1) +: 8] = (3'(i) < fill_inc) ? pk_upd[8*i +: 8] : PAD_BYTE;
    end
  end

  // next state and result
  always_comb begin
    busy_next       = busy;
    bytes_left_next = bytes_left;
    seq_next        = seq;
    fill_next       = fill;
    pk_next         = pk;
    res             = '0;
    unique case (item.opcode)
      OP_START: begin
        busy_next       = 1'b0;
        bytes_left_next = '0;
        fill_next       = '0;
        seq_next        = 8'd1;
        res.valid       = 1'b1;
        priority if (item.message_length < MIN_LENGTH) begin
          res.data.status = ST_TOO_SHORT;
        end else if (packets > PKT_W'(MAX_PACKETS)) begin
          res.data.status = ST_TOO_LONG;
        end else begin
          busy_next                = 1'b1;
          bytes_left_next          = item.message_length;
          res.data.status          = ST_FRAME;
          res.data.frame_pgn       = PGN_TP_CM;
          res.data.destination     = GLOBAL_ADDR;
          res.data.frame_source    = source_address;
          res.data.frame_port      = out_port;
          res.data.payload         = {6'd0, item.message_pgn[17:16],
                                      item.message_pgn[15:8],
                                      item.message_pgn[7:0],
                                      GLOBAL_ADDR,
                                      packets[7:0],
                                      5'd0, item.message_length[10:8],
                                      item.message_length[7:0],
                                      CTRL_BAM};
          res.data.message_done    = 1'b0;
        end
      end
      OP_DATA: begin
        if (!busy) begin
          res.valid       = 1'b1;
          res.data.status = ST_IDLE_DATA;
        end else begin
          pk_next         = pk_upd;
          fill_next       = fill_inc;
          bytes_left_next = left_dec;
          if (fill_inc == 3'(BYTES_PER_PACKET) || left_dec == '0) begin
            res.valid             = 1'b1;
            res.data.status       = ST_FRAME;
            res.data.frame_pgn    = PGN_TP_DT;
            res.data.destination  = GLOBAL_ADDR;
            res.data.frame_source = source_address;
            res.data.frame_port   = out_port;
            res.data.payload      = dt_payload;
            res.data.message_done = (left_dec == '0);
            fill_next             = '0;
            seq_next              = seq + 8'd1;
            if (left_dec == '0) begin
              busy_next = 1'b0;
              seq_next  = 8'd1;
            end
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // message state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      bytes_left <= '0;
      seq        <= 8'd1;
      fill       <= '0;
    end else if (step) begin
      busy       <= busy_next;
      bytes_left <= bytes_left_next;
      seq        <= seq_next;
      fill       <= fill_next;
    end
  end

  // packet buffer
  always_ff @(posedge clk) begin
    if (step) begin
      pk <= pk_next;
    end
  end

  // a packet never holds a full seven bytes between items
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 3'd7)
    else $error("fill count reached seven");

  // idle means nothing pending
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (bytes_left == '0 && fill == '0 && seq == 8'd1))
    else $error("idle with pending message state");

  // a busy message always has bytes to come
  a_busy_left: assert property (@(posedge clk) disable iff (rst)
    busy |-> bytes_left != '0)
    else $error("busy with no bytes left");

  // last frame closes the message
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (step && res.valid && res.data.message_done) |=> !busy)
    else $error("message still busy after final frame");

endmodule

`default_nettype wire

/* sv/bmf_out_stage.sv */
`default_nettype none

module bmf_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bmf_pkg::bmf_res_t res,
  input  wire logic              push,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bmf_pkg::bmf_out_t      out_data
);
  import bmf_pkg::*;

  // register can load when empty or draining this cycle
  assign space = !out_valid || !out_stall;

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (push) begin
      out_data <= res.data;
    end
  end

  // nothing loads over a held result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !push)
    else $error("result overwritten while stalled");

  // only a real result is loaded
  a_push_valid: assert property (@(posedge clk) disable iff (rst)
    push |-> res.valid)
    else $error("empty result loaded");

  // a loaded result shows up next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

/* sv/bam_multipacket_framer.sv */
// Broadcast multipacket transmit framer.
// Input channel (in_valid / in_stall / in_data): a start beat gives message
// length and PGN and yields a TP.CM BAM frame or a length error; each data
// beat adds one byte, and every seventh byte or the final byte yields a TP.DT
// frame padded with 0xFF. A data beat while no message is open yields an
// error result. A start beat always aborts an open message.
// Output channel (out_valid / out_stall / out_data): one result beat per
// frame or error; data beats that fill a packet partway give no result.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): source
// address and output port; cfg_ready is always high, write only while idle.
// An accepted beat sits in the input register, and its result is loaded from
// there into the output register, which drives out_valid and out_data.
// Throughput is one beat per cycle while out_stall does not hold a result,
// set by the single input register feeding the single output register.
// While out_stall holds a result, the input register keeps one more beat and
// in_stall rises only if that beat would produce a result; data beats with
// no result still move through. Reset (synchronous) empties both registers,
// closes any message and sets source address 0, output port 1.
`default_nettype none

module bam_multipacket_framer (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bmf_pkg::bmf_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bmf_pkg::bmf_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire bmf_pkg::cfg_index_t cfg_index,
  input  wire logic [7:0]        cfg_data
);
  import bmf_pkg::*;

  logic       s1_valid;
  bmf_in_t    s1_item;
  logic       go;
  logic       space;
  bmf_res_t   res;
  logic [7:0] source_address;
  logic [1:0] out_port;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= 8'd0;
      out_port       <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE_ADDRESS: source_address <= cfg_data;
        CFG_OUT_PORT:       out_port       <= cfg_data[1:0];
        default:            source_address <= source_address;
      endcase
    end
  end

  // input register advances unless its result has nowhere to go
  assign go       = s1_valid && (!res.valid || space);
  assign in_stall = s1_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_data;
    end
  end

  bmf_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .item           (s1_item),
    .step           (go),
    .source_address (source_address),
    .out_port       (out_port),
    .res            (res)
  );

  bmf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res       (res),
    .push      (go && res.valid),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a held input beat only waits on a full output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && res.valid))
    else $error("input stalled without a blocked result");

  // a stalled input beat stays in the register
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !go) |=> (s1_valid && $stable(s1_item)))
    else $error("input register lost a beat");

  // an accepted beat is always registered
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted beat not registered");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
  import bmf_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  bmf_in_t    in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  bmf_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  cfg_index_t cfg_index = CFG_SOURCE_ADDRESS;
  logic [7:0] cfg_data = 8'h00;

  // beats waiting to be sent, frames waiting to come out
  bmf_in_t  tx_beats[$];
  bmf_out_t expected_frames[$];
  int       mismatches = 0;

  // idle burst odds, 0 means no idling
  int gap_odds = 0;
  int stall_odds = 0;
  int in_gap = 0;
  int stall_left = 0;

  // framer state as the testbench sees it
  logic        msg_open = 1'b0;
  logic [10:0] bytes_left = '0;
  logic [7:0]  seq_num = 8'd1;
  logic [2:0]  fill = '0;
  logic [55:0] pkt_bytes = '0;
  logic [7:0]  src_addr = 8'd0;
  logic [1:0]  port_sel = 2'd1;

  bam_multipacket_framer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // work out the frame (if any) that one accepted beat produces
  task automatic frame_message_beat(input bmf_in_t b);
    bmf_out_t    r;
    logic [10:0] len;
    logic [63:0] pay;
    logic [2:0]  pos;
    logic        done;
    int          pkt_count;
    r = '0;
    if (b.opcode == OP_START) begin
      len = b.message_length;
      pkt_count = (int'(len) + BYTES_PER_PACKET - 1) / BYTES_PER_PACKET;
      msg_open = 1'b0;
      bytes_left = '0;
      fill = '0;
      seq_num = 8'd1;
      if (len < MIN_LENGTH) begin
        r.status = ST_TOO_SHORT;
      end else if (pkt_count > MAX_PACKETS) begin
        r.status = ST_TOO_LONG;
      end else begin
        pay = {6'b0, b.message_pgn[17:16], b.message_pgn[15:8], b.message_pgn[7:0],
               GLOBAL_ADDR, pkt_count[7:0], 5'b0, len[10:8], len[7:0], CTRL_BAM};
        msg_open = 1'b1;
        bytes_left = len;
        r.status = ST_FRAME;
        r.frame_pgn = PGN_TP_CM;
        r.destination = GLOBAL_ADDR;
        r.frame_source = src_addr;
        r.frame_port = port_sel;
        r.payload = pay;
      end
      expected_frames.push_back(r);
    end else if (!msg_open) begin
      r.status = ST_IDLE_DATA;
      expected_frames.push_back(r);
    end else begin
      pos = fill;
      pkt_bytes[pos*8 +: 8] = b.data_byte;
      fill = pos + 3'd1;
      bytes_left = bytes_left - 11'd1;
      if (fill == BYTES_PER_PACKET || bytes_left == 0) begin
        done = (bytes_left == 0);
        pay = '0;
        pay[7:0] = seq_num;
        for (int i = 0; i < BYTES_PER_PACKET; i++)
          pay[(i+1)*8 +: 8] = (i < fill) ? pkt_bytes[i*8 +: 8] : PAD_BYTE;
        seq_num = seq_num + 8'd1;
        fill = '0;
        if (done) begin
          msg_open = 1'b0;
          seq_num = 8'd1;
        end
        r.status = ST_FRAME;
        r.frame_pgn = PGN_TP_DT;
        r.destination = GLOBAL_ADDR;
        r.frame_source = src_addr;
        r.frame_port = port_sel;
        r.payload = pay;
        r.message_done = done;
        expected_frames.push_back(r);
      end
    end
  endtask

  // input driver: holds a stalled beat, otherwise idles in bursts or sends the next
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        frame_message_beat(in_data);
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
          in_gap = $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else if (tx_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= tx_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output backpressure in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // monitor: every result beat against the oldest expected frame
  always @(posedge clk) begin
    bmf_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = expected_frames.pop_front();
        check_field("status", 64'(want.status), 64'(out_data.status));
        check_field("frame_pgn", 64'(want.frame_pgn), 64'(out_data.frame_pgn));
        check_field("destination", 64'(want.destination), 64'(out_data.destination));
        check_field("frame_source", 64'(want.frame_source), 64'(out_data.frame_source));
        check_field("frame_port", 64'(want.frame_port), 64'(out_data.frame_port));
        check_field("payload", want.payload, out_data.payload);
        check_field("message_done", 64'(want.message_done), 64'(out_data.message_done));
      end
    end
  end

  function automatic bmf_in_t start_beat(input logic [10:0] len, input logic [17:0] pgn);
    bmf_in_t b;
    b.opcode = OP_START;
    b.message_length = len;
    b.message_pgn = pgn;
    b.data_byte = 8'($urandom);
    return b;
  endfunction

  function automatic bmf_in_t data_beat(input logic [7:0] value);
    bmf_in_t b;
    b.opcode = OP_DATA;
    b.message_length = 11'($urandom);
    b.message_pgn = 18'($urandom);
    b.data_byte = value;
    return b;
  endfunction

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SOURCE_ADDRESS)
      src_addr = value;
    else
      port_sel = value[1:0];
    cfg_valid <= 1'b0;
  endtask

  // wait until every beat is in and every frame is out, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (tx_beats.size() != 0 || in_valid || expected_frames.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // messages with random content: mostly complete, some aborted, some rejected
  task automatic queue_random_messages(input int budget);
    int          n;
    int          kind;
    int          msg_len;
    int          keep;
    int          extra;
    int          pick;
    logic [17:0] pgn;
    n = 0;
    while (n < budget) begin
      kind = $urandom_range(0, 99);
      pgn = 18'($urandom);
      if (kind < 15) begin
        msg_len = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(1786, 2047);
        tx_beats.push_back(start_beat(11'(msg_len), pgn));
        n++;
        extra = $urandom_range(0, 2);
      end else begin
        if (kind < 25) begin
          msg_len = $urandom_range(8, 1785);
          keep = $urandom_range(0, (msg_len - 1 < 60) ? msg_len - 1 : 60);
          extra = 0;
        end else begin
          pick = $urandom_range(0, 9);
          if (pick < 6)
            msg_len = $urandom_range(8, 30);
          else if (pick < 9)
            msg_len = $urandom_range(31, 120);
          else
            msg_len = $urandom_range(121, 400);
          keep = msg_len;
          extra = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
        end
        tx_beats.push_back(start_beat(11'(msg_len), pgn));
        n++;
        repeat (keep) tx_beats.push_back(data_beat(8'($urandom)));
        n += keep;
      end
      // data after the message is over lands on an idle framer
      repeat (extra) tx_beats.push_back(data_beat(8'($urandom)));
      n += extra;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_SOURCE_ADDRESS, 8'h00);
    write_reg(CFG_OUT_PORT, 8'h01);
    gap_odds = 6;
    stall_odds = 5;
    @(negedge clk);

    // length limits, idle data, abort, packet boundary with padding
    tx_beats.push_back(start_beat(11'd0, 18'h00000));
    tx_beats.push_back(start_beat(11'd7, 18'h3FFFF));
    tx_beats.push_back(start_beat(11'd1786, 18'h00000));
    tx_beats.push_back(start_beat(11'd2047, 18'h3FFFF));
    tx_beats.push_back(data_beat(8'h00));
    tx_beats.push_back(start_beat(11'd1785, 18'h3FFFF));
    tx_beats.push_back(data_beat(8'hFF));
    tx_beats.push_back(data_beat(8'h00));
    tx_beats.push_back(start_beat(11'd8, 18'h00000));
    tx_beats.push_back(data_beat(8'h00));
    tx_beats.push_back(data_beat(8'hFF));
    tx_beats.push_back(data_beat(8'h55));
    tx_beats.push_back(data_beat(8'hAA));
    tx_beats.push_back(data_beat(8'h01));
    tx_beats.push_back(data_beat(8'h80));
    tx_beats.push_back(data_beat(8'h7F));
    tx_beats.push_back(data_beat(8'hFE));
    tx_beats.push_back(data_beat(8'h3C));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_SOURCE_ADDRESS, 8'hFF);
          write_reg(CFG_OUT_PORT, 8'h03);
          gap_odds = 4;
          stall_odds = 3;
        end
        1: begin
          // port zero goes out unchanged
          write_reg(CFG_SOURCE_ADDRESS, 8'($urandom));
          write_reg(CFG_OUT_PORT, {6'($urandom), 2'b00});
          gap_odds = 0;
          stall_odds = 8;
        end
        2: begin
          write_reg(CFG_SOURCE_ADDRESS, 8'($urandom));
          write_reg(CFG_OUT_PORT, 8'($urandom));
          gap_odds = 10;
          stall_odds = 0;
        end
        default: begin
          write_reg(CFG_SOURCE_ADDRESS, 8'h00);
          write_reg(CFG_OUT_PORT, 8'h02);
          gap_odds = 0;
          stall_odds = 0;
        end
      endcase
      @(negedge clk);
      queue_random_messages(275);
      // a rejected start closes any open message before the next register write
      tx_beats.push_back(start_beat(11'($urandom_range(0, 7)), 18'($urandom)));
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
sv/bmf_pkg.sv
sv/bmf_framer.sv
sv/bmf_out_stage.sv
sv/bam_multipacket_framer.sv
tb/tb.sv
